// ===== design/ppts_pkg.sv =====
// ----------------------------------------------------------------------------
// ppts_pkg: shared types and constants
// Task record layout, operation codes, sequencer states and default sizes
// for the preemptive priority task selector.
// ----------------------------------------------------------------------------
package ppts_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int FRAC_BITS_DEF = 8;

   localparam int TIME_W     = 16;
   localparam int PRIO_W     = 8;
   localparam int FUNC_W     = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int MEAN_W     = 24;

   localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_REPORT = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_SCAN,
      ST_TICK_FIX,
      ST_RPT_SCAN,
      ST_RPT_T_GO,
      ST_RPT_T_WAIT,
      ST_RPT_W_GO,
      ST_RPT_W_WAIT,
      ST_PUSH
   } state_type;

   // One table entry, held as a single memory word.
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] progress;
      logic [TIME_W-1:0] turn;
   } task_rec_type;

endpackage

// ===== design/preemptive_priority_task_selector_top.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_task_selector_top: priority task table and scheduler
// Holds up to MAX_TASKS tasks in a memory and serves load, tick and report.
// ----------------------------------------------------------------------------
// Use:
//   Request channel (req_*): one operation per transfer. req_func selects
//   load (append a task), tick (choose and advance at time req_now),
//   report (mean turnaround and wait, unsigned fixed point with FRAC_BITS
//   fraction bits, truncated) or no operation.
//   Response channel (rsp_*): exactly one response per request, in order.
//   Fields that do not belong to the operation read as zero.
// Work per operation:
//   tick   : one table read per slot, through the single memory read port.
//   report : one table read per slot, then two divisions in the serial
//            divider (DVD_W = 30 at default sizes), skipped with an empty
//            table.
//   One request is in work at a time; the next is taken once the response
//   sits in the output register, even while the receiver stalls it.
// Reset: task count cleared, no response pending. Table entries are not
//   cleared; only slots below the count are ever read.
// Stall: rsp_stall holds the response register; the block then finishes
//   its next request and waits with the result until the register frees.
// ----------------------------------------------------------------------------
module preemptive_priority_task_selector_top #(
   parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF,
   parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ppts_pkg::FUNC_W-1:0]     req_func,
   input  logic [ppts_pkg::TIME_W-1:0]     req_arrival_time,
   input  logic [ppts_pkg::TIME_W-1:0]     req_burst_length,
   input  logic [ppts_pkg::PRIO_W-1:0]     req_task_priority,
   input  logic [ppts_pkg::TIME_W-1:0]     req_now,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_chosen_valid,
   output logic [ppts_pkg::SLOT_OUT_W-1:0] rsp_chosen_slot,
   output logic                            rsp_all_done,
   output logic                            rsp_load_rejected,
   output logic                            rsp_averages_valid,
   output logic [ppts_pkg::MEAN_W-1:0]     rsp_mean_turnaround,
   output logic [ppts_pkg::MEAN_W-1:0]     rsp_mean_wait
);

   // Count holds 0..MAX_TASKS; slot index addresses MAX_TASKS entries.
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   // Signed sums: each term spans +/- 2^17, up to MAX_TASKS terms.
   localparam int SUM_W = 18 + CNT_W;
   localparam int DVD_W = SUM_W - 1 + FRAC_BITS;
   localparam int EXT_W = (DVD_W > ppts_pkg::MEAN_W) ? DVD_W : ppts_pkg::MEAN_W + 1;

   ppts_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]       task_count_ff, task_count_in;
   logic [CNT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   dv_ff, dv_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic [ppts_pkg::TIME_W-1:0] now_ff, now_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_slot_ff, best_slot_in;
   ppts_pkg::task_rec_type best_rec_ff, best_rec_in;
   logic [1:0]             unf_ff, unf_in;
   logic [SUM_W-1:0]       turn_sum_ff, turn_sum_in;
   logic [SUM_W-1:0]       wait_sum_ff, wait_sum_in;

   // result held until the output register is free
   logic                   res_chosen_valid_ff, res_chosen_valid_in;
   logic [ppts_pkg::SLOT_OUT_W-1:0] res_chosen_slot_ff, res_chosen_slot_in;
   logic                   res_all_done_ff, res_all_done_in;
   logic                   res_load_rejected_ff, res_load_rejected_in;
   logic                   res_averages_valid_ff, res_averages_valid_in;
   logic [ppts_pkg::MEAN_W-1:0] res_mean_turn_ff, res_mean_turn_in;
   logic [ppts_pkg::MEAN_W-1:0] res_mean_wait_ff, res_mean_wait_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_chosen_valid_ff;
   logic [ppts_pkg::SLOT_OUT_W-1:0] rsp_chosen_slot_ff;
   logic                   rsp_all_done_ff;
   logic                   rsp_load_rejected_ff;
   logic                   rsp_averages_valid_ff;
   logic [ppts_pkg::MEAN_W-1:0] rsp_mean_turn_ff;
   logic [ppts_pkg::MEAN_W-1:0] rsp_mean_wait_ff;
   logic                   rsp_load;

   // memory and divider hookup
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   ppts_pkg::task_rec_type mem_wdata;
   logic [IDX_W-1:0]       mem_raddr;
   ppts_pkg::task_rec_type mem_rdata;
   logic                   div_start;
   logic [DVD_W-1:0]       div_dividend;
   logic                   div_done;
   logic [DVD_W-1:0]       div_quot;

   logic                   req_take;
   logic                   scanning;
   logic                   scan_issue;
   logic                   scan_end;
   logic                   unfinished;
   logic                   ready;
   logic                   better;
   ppts_pkg::task_rec_type upd_rec;
   ppts_pkg::task_rec_type fix_rec;
   logic [EXT_W-1:0]       quot_ext;
   logic [ppts_pkg::MEAN_W-1:0] mean_sat;
   logic                   turn_pos;
   logic                   wait_pos;

   ppts_store #(
      .DEPTH (MAX_TASKS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ppts_div #(
      .DVD_W (DVD_W),
      .DSR_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (task_count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != ppts_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Scan pipeline: issue one read per cycle, handle its data in the cycle after.
   assign scanning   = state_ff inside {ppts_pkg::ST_TICK_SCAN, ppts_pkg::ST_RPT_SCAN};
   assign scan_issue = scanning && (rd_ptr_ff < task_count_ff);
   assign scan_end   = (rd_ptr_ff == task_count_ff) && !dv_ff;
   assign mem_raddr  = rd_ptr_ff[IDX_W-1:0];

   // Per-entry tick decisions on the word just read.
   assign unfinished = (mem_rdata.progress != mem_rdata.burst);
   assign ready      = unfinished && (mem_rdata.arrival <= now_ff);
   assign better     = !found_ff || (mem_rdata.prio < best_rec_ff.prio) ||
                       ((mem_rdata.prio == best_rec_ff.prio) &&
                        (mem_rdata.arrival < best_rec_ff.arrival));

   always_comb begin
      upd_rec      = mem_rdata;
      upd_rec.turn = mem_rdata.turn + 1'b1;
      fix_rec          = best_rec_ff;
      fix_rec.progress = best_rec_ff.progress + 1'b1;
   end

   // Mean clamp: quotient above the field width saturates.
   assign quot_ext = EXT_W'(div_quot);
   assign mean_sat = (quot_ext > EXT_W'(ppts_pkg::MEAN_MAX)) ? ppts_pkg::MEAN_MAX
                                                             : quot_ext[ppts_pkg::MEAN_W-1:0];

   // A sum at or below zero gives a zero mean: divide zero then.
   assign turn_pos = !turn_sum_ff[SUM_W-1] && (turn_sum_ff != '0);
   assign wait_pos = !wait_sum_ff[SUM_W-1] && (wait_sum_ff != '0);

   assign rsp_load = (state_ff == ppts_pkg::ST_PUSH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      task_count_in = task_count_ff;
      rd_ptr_in     = rd_ptr_ff;
      dv_in         = 1'b0;
      slot_in       = slot_ff;
      now_in        = now_ff;
      found_in      = found_ff;
      best_slot_in  = best_slot_ff;
      best_rec_in   = best_rec_ff;
      unf_in        = unf_ff;
      turn_sum_in   = turn_sum_ff;
      wait_sum_in   = wait_sum_ff;

      res_chosen_valid_in   = res_chosen_valid_ff;
      res_chosen_slot_in    = res_chosen_slot_ff;
      res_all_done_in       = res_all_done_ff;
      res_load_rejected_in  = res_load_rejected_ff;
      res_averages_valid_in = res_averages_valid_ff;
      res_mean_turn_in      = res_mean_turn_ff;
      res_mean_wait_in      = res_mean_wait_ff;

      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = upd_rec;
      div_start    = 1'b0;
      div_dividend = turn_pos ? (DVD_W'(turn_sum_ff[SUM_W-2:0]) << FRAC_BITS) : '0;

      if (scan_issue) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         dv_in     = 1'b1;
         slot_in   = rd_ptr_ff[IDX_W-1:0];
      end

      case (state_ff)
         ppts_pkg::ST_IDLE: begin
            if (req_take) begin
               // clear the result; each operation fills only its own fields
               res_chosen_valid_in   = 1'b0;
               res_chosen_slot_in    = '0;
               res_all_done_in       = 1'b0;
               res_load_rejected_in  = 1'b0;
               res_averages_valid_in = 1'b0;
               res_mean_turn_in      = '0;
               res_mean_wait_in      = '0;
               rd_ptr_in   = '0;
               found_in    = 1'b0;
               unf_in      = 2'd0;
               turn_sum_in = '0;
               wait_sum_in = '0;
               now_in      = req_now;
               case (ppts_pkg::func_type'(req_func))
                  ppts_pkg::FUNC_LOAD: begin
                     if (task_count_ff >= CNT_W'(MAX_TASKS)) begin
                        res_load_rejected_in = 1'b1;
                     end else begin
                        mem_we             = 1'b1;
                        mem_waddr          = task_count_ff[IDX_W-1:0];
                        mem_wdata.arrival  = req_arrival_time;
                        mem_wdata.burst    = req_burst_length;
                        mem_wdata.prio     = req_task_priority;
                        mem_wdata.progress = '0;
                        mem_wdata.turn     = '0;
                        task_count_in      = task_count_ff + 1'b1;
                     end
                     state_in = ppts_pkg::ST_PUSH;
                  end
                  ppts_pkg::FUNC_TICK:   state_in = ppts_pkg::ST_TICK_SCAN;
                  ppts_pkg::FUNC_REPORT: state_in = ppts_pkg::ST_RPT_SCAN;
                  default:               state_in = ppts_pkg::ST_PUSH;
               endcase
            end
         end

         ppts_pkg::ST_TICK_SCAN: begin
            if (dv_ff && unfinished) begin
               // advance the turn counter of every unfinished task
               mem_we    = 1'b1;
               mem_waddr = slot_ff;
               mem_wdata = upd_rec;
               unf_in    = (unf_ff == 2'd2) ? 2'd2 : unf_ff + 2'd1;
               if (ready && better) begin
                  found_in     = 1'b1;
                  best_slot_in = slot_ff;
                  best_rec_in  = upd_rec;
               end
            end
            if (scan_end) begin
               state_in = ppts_pkg::ST_TICK_FIX;
            end
         end

         ppts_pkg::ST_TICK_FIX: begin
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = best_slot_ff;
               mem_wdata = fix_rec;
            end
            res_chosen_valid_in = found_ff;
            res_chosen_slot_in  = found_ff ? ppts_pkg::SLOT_OUT_W'(best_slot_ff) : '0;
            // done when nothing was left, or the chosen task was the last one left and now finishes
            res_all_done_in = (unf_ff == 2'd0) ||
                              ((unf_ff == 2'd1) && found_ff &&
                               (fix_rec.progress == best_rec_ff.burst));
            state_in = ppts_pkg::ST_PUSH;
         end

         ppts_pkg::ST_RPT_SCAN: begin
            if (dv_ff) begin
               turn_sum_in = turn_sum_ff + SUM_W'(mem_rdata.turn) -
                             SUM_W'(mem_rdata.arrival);
               wait_sum_in = wait_sum_ff + SUM_W'(mem_rdata.turn) -
                             SUM_W'(mem_rdata.arrival) - SUM_W'(mem_rdata.burst);
            end
            if (scan_end) begin
               state_in = (task_count_ff == '0) ? ppts_pkg::ST_PUSH
                                                : ppts_pkg::ST_RPT_T_GO;
            end
         end

         ppts_pkg::ST_RPT_T_GO: begin
            div_start = 1'b1;
            state_in  = ppts_pkg::ST_RPT_T_WAIT;
         end

         ppts_pkg::ST_RPT_T_WAIT: begin
            if (div_done) begin
               res_mean_turn_in = mean_sat;
               state_in         = ppts_pkg::ST_RPT_W_GO;
            end
         end

         ppts_pkg::ST_RPT_W_GO: begin
            div_start    = 1'b1;
            div_dividend = wait_pos ? (DVD_W'(wait_sum_ff[SUM_W-2:0]) << FRAC_BITS) : '0;
            state_in     = ppts_pkg::ST_RPT_W_WAIT;
         end

         ppts_pkg::ST_RPT_W_WAIT: begin
            if (div_done) begin
               res_mean_wait_in      = mean_sat;
               res_averages_valid_in = 1'b1;
               state_in              = ppts_pkg::ST_PUSH;
            end
         end

         ppts_pkg::ST_PUSH: begin
            if (rsp_load) begin
               state_in = ppts_pkg::ST_IDLE;
            end
         end

         default: state_in = ppts_pkg::ST_IDLE;
      endcase
   end

   // Output register: load from the held result, drop once transferred.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppts_pkg::ST_IDLE;
         task_count_ff <= '0;
         dv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         dv_ff         <= dv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      slot_ff      <= slot_in;
      now_ff       <= now_in;
      found_ff     <= found_in;
      best_slot_ff <= best_slot_in;
      best_rec_ff  <= best_rec_in;
      unf_ff       <= unf_in;
      turn_sum_ff  <= turn_sum_in;
      wait_sum_ff  <= wait_sum_in;

      res_chosen_valid_ff   <= res_chosen_valid_in;
      res_chosen_slot_ff    <= res_chosen_slot_in;
      res_all_done_ff       <= res_all_done_in;
      res_load_rejected_ff  <= res_load_rejected_in;
      res_averages_valid_ff <= res_averages_valid_in;
      res_mean_turn_ff      <= res_mean_turn_in;
      res_mean_wait_ff      <= res_mean_wait_in;

      if (rsp_load) begin
         rsp_chosen_valid_ff   <= res_chosen_valid_ff;
         rsp_chosen_slot_ff    <= res_chosen_slot_ff;
         rsp_all_done_ff       <= res_all_done_ff;
         rsp_load_rejected_ff  <= res_load_rejected_ff;
         rsp_averages_valid_ff <= res_averages_valid_ff;
         rsp_mean_turn_ff      <= res_mean_turn_ff;
         rsp_mean_wait_ff      <= res_mean_wait_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_valid    = rsp_chosen_valid_ff;
   assign rsp_chosen_slot     = rsp_chosen_slot_ff;
   assign rsp_all_done        = rsp_all_done_ff;
   assign rsp_load_rejected   = rsp_load_rejected_ff;
   assign rsp_averages_valid  = rsp_averages_valid_ff;
   assign rsp_mean_turnaround = rsp_mean_turn_ff;
   assign rsp_mean_wait       = rsp_mean_wait_ff;

   // Table never overfills.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      task_count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count above table size");

   // An accepted load into a table with room appends exactly one task.
   a_load_appends: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_func == ppts_pkg::FUNC_LOAD) &&
       (task_count_ff < CNT_W'(MAX_TASKS)))
      |=> (task_count_ff == CNT_W'($past(task_count_ff) + 1'b1)))
      else $error("load did not append one task");

   // Count only moves on a transfer taken in idle.
   a_count_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ppts_pkg::ST_IDLE) |=> $stable(task_count_ff))
      else $error("task count changed during an operation");

   // Scan write-back never targets the slot being read in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && scan_issue) |-> (mem_waddr != mem_raddr))
      else $error("read and write to the same table slot");

   // A response only appears from the hand-off state.
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ppts_pkg::ST_PUSH))
      else $error("response raised outside hand-off");

endmodule

// ===== design/ppts_store.sv =====
// ----------------------------------------------------------------------------
// ppts_store: task table memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ppts_store #(
   parameter int DEPTH = ppts_pkg::MAX_TASKS_DEF,
   parameter int IDX_W = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  ppts_pkg::task_rec_type wr_data,
   input  logic [IDX_W-1:0]       rd_addr,
   output ppts_pkg::task_rec_type rd_data
);

   ppts_pkg::task_rec_type mem [DEPTH];
   ppts_pkg::task_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ppts_div.sv =====
// ----------------------------------------------------------------------------
// ppts_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module ppts_div #(
   parameter int DVD_W = 30,
   parameter int DSR_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;

   logic [DSR_W:0]   rem_sh;
   logic [DSR_W+1:0] diff;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign ge     = ~diff[DSR_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where it fits
         rem_in = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
